// ----- hdl/adaf_pkg.sv -----
package adaf_pkg;

  localparam int MAX_SLOTS  = 512;
  localparam int SLOT_W     = $clog2(MAX_SLOTS + 1);
  localparam int HDR_LEN    = 18;
  localparam int MIN_LEN    = 10;
  localparam int VER_LEN    = 12;
  localparam int PROT_MIN   = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_DMX   = 2'd0,
    CMD_SYNC  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_STATS = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_BAD_ID    = 3'd1,
    VERDICT_OLD_PROTO = 3'd2,
    VERDICT_UNIVERSE  = 3'd3,
    VERDICT_TRUNC     = 3'd4,
    VERDICT_LOCKED    = 3'd5,
    VERDICT_STALE     = 3'd6,
    VERDICT_NONE      = 3'd7
  } verdict_t;

  typedef enum logic [1:0] {
    TGT_NONE   = 2'd0,
    TGT_LIVE   = 2'd1,
    TGT_SHADOW = 2'd2
  } target_t;

  typedef enum logic [1:0] {
    REG_MY_UNIVERSE  = 2'd0,
    REG_STALE_WINDOW = 2'd1,
    REG_SYNC_TIMEOUT = 2'd2
  } reg_idx_t;

  localparam logic [15:0] STALE_WINDOW_RST = 16'd1000;
  localparam logic [15:0] SYNC_TIMEOUT_RST = 16'd4000;

  typedef struct packed {
    logic [14:0] my_universe;
    logic [15:0] stale_window_ms;
    logic [15:0] sync_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        header_ok;
    logic [10:0] packet_length;
    logic [15:0] prot_version;
    logic [31:0] sender_ip;
    logic [15:0] universe;
    logic [15:0] data_length;
    logic [7:0]  sequence_req;
  } item_t;

  typedef struct packed {
    logic [2:0]        verdict;
    logic [1:0]        write_target;
    logic [SLOT_W-1:0] slot_count;
    logic              commit_shadow;
    logic [SLOT_W-1:0] commit_length;
    logic              in_sync_mode;
    logic              sender_swapped;
    logic [31:0]       stale_total;
    logic [31:0]       locked_total;
    logic [31:0]       accepted_total;
    logic [31:0]       bad_proto_total;
  } result_t;

endpackage

// ----- hdl/artnet_dmx_accept_filter.sv -----
// An item passes two registers in order: the input register, then the result register.
// One item per cycle unless out_stall holds a valid result; the decision logic between
// the two registers updates the filter state in the same cycle the result is registered.
// Reset (rst_n low, synchronous): both stages empty, filter state and counters
// cleared, my_universe 0, stale_window_ms 1000, sync_timeout_ms 4000.
module artnet_dmx_accept_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic                                in_header_ok,
  input  logic [10:0]                         in_packet_length,
  input  logic [15:0]                         in_prot_version,
  input  logic [31:0]                         in_sender_ip,
  input  logic [15:0]                         in_universe,
  input  logic [15:0]                         in_data_length,
  input  logic [7:0]                          in_sequence_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_verdict,
  output logic [1:0]                          out_write_target,
  output logic [adaf_pkg::SLOT_W-1:0]         out_slot_count,
  output logic                                out_commit_shadow,
  output logic [adaf_pkg::SLOT_W-1:0]         out_commit_length,
  output logic                                out_in_sync_mode,
  output logic                                out_sender_swapped,
  output logic [31:0]                         out_stale_total,
  output logic [31:0]                         out_locked_total,
  output logic [31:0]                         out_accepted_total,
  output logic [31:0]                         out_bad_proto_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adaf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adaf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  adaf_pkg::cfg_t    cfg;
  adaf_pkg::item_t   item_r;
  adaf_pkg::result_t res;
  adaf_pkg::result_t res_r;
  logic              item_vld_r;
  logic              out_vld_r;
  logic              advance;
  logic              fire;
  logic              in_xfer;

  assign cfg_ready = 1'b1;

  adaf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = item_vld_r && advance;
  assign in_stall = item_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (advance || !item_vld_r) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.command       <= in_command;
      item_r.header_ok     <= in_header_ok;
      item_r.packet_length <= in_packet_length;
      item_r.prot_version  <= in_prot_version;
      item_r.sender_ip     <= in_sender_ip;
      item_r.universe      <= in_universe;
      item_r.data_length   <= in_data_length;
      item_r.sequence_req  <= in_sequence_req;
    end
  end

  adaf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_verdict         = res_r.verdict;
  assign out_write_target    = res_r.write_target;
  assign out_slot_count      = res_r.slot_count;
  assign out_commit_shadow   = res_r.commit_shadow;
  assign out_commit_length   = res_r.commit_length;
  assign out_in_sync_mode    = res_r.in_sync_mode;
  assign out_sender_swapped  = res_r.sender_swapped;
  assign out_stale_total     = res_r.stale_total;
  assign out_locked_total    = res_r.locked_total;
  assign out_accepted_total  = res_r.accepted_total;
  assign out_bad_proto_total = res_r.bad_proto_total;

  a_write_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_target != adaf_pkg::TGT_NONE) |->
      (out_verdict == adaf_pkg::VERDICT_ACCEPT))
    else $error("store write without accept verdict");

  a_shadow_in_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_write_target == adaf_pkg::TGT_SHADOW) |-> out_in_sync_mode)
    else $error("shadow write outside sync mode");

  a_commit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_commit_shadow |-> (out_commit_length == '0))
    else $error("commit length without commit");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free result register");

endmodule

// ----- hdl/adaf_cfg_regs.sv -----
module adaf_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [adaf_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  logic [adaf_pkg::CFG_DATA_W-1:0]   wr_data,
  output adaf_pkg::cfg_t                    cfg
);

  adaf_pkg::cfg_t cfg_r;
  adaf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        adaf_pkg::REG_MY_UNIVERSE:  cfg_nxt.my_universe     = wr_data[14:0];
        adaf_pkg::REG_STALE_WINDOW: cfg_nxt.stale_window_ms = wr_data;
        adaf_pkg::REG_SYNC_TIMEOUT: cfg_nxt.sync_timeout_ms = wr_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_universe     <= '0;
      cfg_r.stale_window_ms <= adaf_pkg::STALE_WINDOW_RST;
      cfg_r.sync_timeout_ms <= adaf_pkg::SYNC_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/adaf_core.sv -----
module adaf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  adaf_pkg::cfg_t    cfg,
  input  adaf_pkg::item_t   item,
  output adaf_pkg::result_t res
);

  localparam int SW = adaf_pkg::SLOT_W;

  logic [31:0]   now_r, now_nxt;
  logic          pvalid_r, pvalid_nxt;
  logic [31:0]   psender_r, psender_nxt;
  logic [31:0]   plast_r, plast_nxt;
  logic [7:0]    lseq_r, lseq_nxt;
  logic [31:0]   lseq_sender_r, lseq_sender_nxt;
  logic          sync_r, sync_nxt;
  logic [31:0]   last_sync_r, last_sync_nxt;
  logic          dirty_r, dirty_nxt;
  logic [SW-1:0] shadow_slots_r, shadow_slots_nxt;
  logic [31:0]   stale_cnt_r, stale_cnt_nxt;
  logic [31:0]   locked_cnt_r, locked_cnt_nxt;
  logic [31:0]   acc_cnt_r, acc_cnt_nxt;
  logic [31:0]   bad_cnt_r, bad_cnt_nxt;

  logic [31:0]   now_inc;
  logic [31:0]   sync_age;
  logic [31:0]   prim_age;
  logic [SW-1:0] n_slots;
  logic [11:0]   need_len;
  logic          other_sender;
  logic [7:0]    lseq_eff;
  logic [7:0]    seq_diff;

  assign now_inc  = now_r + 32'd1;
  assign sync_age = now_inc - last_sync_r;
  assign prim_age = now_r - plast_r;
  assign n_slots  = (item.data_length > 16'(adaf_pkg::MAX_SLOTS)) ?
                    SW'(adaf_pkg::MAX_SLOTS) : item.data_length[SW-1:0];
  assign need_len = 12'(adaf_pkg::HDR_LEN) + 12'(n_slots);
  assign other_sender = pvalid_r && (item.sender_ip != psender_r);

  always_comb begin
    now_nxt          = now_r;
    pvalid_nxt       = pvalid_r;
    psender_nxt      = psender_r;
    plast_nxt        = plast_r;
    lseq_nxt         = lseq_r;
    lseq_sender_nxt  = lseq_sender_r;
    sync_nxt         = sync_r;
    last_sync_nxt    = last_sync_r;
    dirty_nxt        = dirty_r;
    shadow_slots_nxt = shadow_slots_r;
    stale_cnt_nxt    = stale_cnt_r;
    locked_cnt_nxt   = locked_cnt_r;
    acc_cnt_nxt      = acc_cnt_r;
    bad_cnt_nxt      = bad_cnt_r;
    lseq_eff         = lseq_r;
    seq_diff         = '0;
    res              = '0;
    res.verdict      = adaf_pkg::VERDICT_NONE;
    res.write_target = adaf_pkg::TGT_NONE;

    case (item.command)
      adaf_pkg::CMD_TICK: begin
        now_nxt = now_inc;
        if (sync_r && (sync_age > {16'd0, cfg.sync_timeout_ms})) begin
          sync_nxt = 1'b0;
          if (dirty_r) begin
            dirty_nxt         = 1'b0;
            res.commit_shadow = 1'b1;
            res.commit_length = shadow_slots_r;
          end
        end
      end
      adaf_pkg::CMD_STATS: begin
        stale_cnt_nxt  = '0;
        locked_cnt_nxt = '0;
      end
      default: begin
        if (!item.header_ok || item.packet_length < 11'(adaf_pkg::MIN_LEN)) begin
          res.verdict = adaf_pkg::VERDICT_BAD_ID;
        end else if (item.packet_length >= 11'(adaf_pkg::VER_LEN) &&
                     item.prot_version < 16'(adaf_pkg::PROT_MIN)) begin
          bad_cnt_nxt = bad_cnt_r + 32'd1;
          res.verdict = adaf_pkg::VERDICT_OLD_PROTO;
        end else if (item.command == adaf_pkg::CMD_SYNC) begin
          sync_nxt      = 1'b1;
          last_sync_nxt = now_r;
          if (dirty_r) begin
            dirty_nxt         = 1'b0;
            res.commit_shadow = 1'b1;
            res.commit_length = shadow_slots_r;
          end
        end else if (item.packet_length < 11'(adaf_pkg::HDR_LEN)) begin
          res.verdict = adaf_pkg::VERDICT_BAD_ID;
        end else if (item.universe != {1'b0, cfg.my_universe}) begin
          res.verdict = adaf_pkg::VERDICT_UNIVERSE;
        end else if ({1'b0, item.packet_length} < need_len) begin
          res.verdict = adaf_pkg::VERDICT_TRUNC;
        end else if (other_sender && (prim_age < {16'd0, cfg.stale_window_ms})) begin
          locked_cnt_nxt = locked_cnt_r + 32'd1;
          res.verdict    = adaf_pkg::VERDICT_LOCKED;
        end else begin
          if (other_sender) begin
            lseq_eff = '0;
            lseq_nxt = '0;
          end
          seq_diff = item.sequence_req - lseq_eff;
          if (item.sequence_req != 8'd0 && item.sender_ip == lseq_sender_r &&
              lseq_eff != 8'd0 && seq_diff[7]) begin
            stale_cnt_nxt = stale_cnt_r + 32'd1;
            res.verdict   = adaf_pkg::VERDICT_STALE;
          end else begin
            if (item.sequence_req != 8'd0) begin
              lseq_nxt        = item.sequence_req;
              lseq_sender_nxt = item.sender_ip;
            end
            res.verdict    = adaf_pkg::VERDICT_ACCEPT;
            res.slot_count = n_slots;
            if (sync_r) begin
              res.write_target = adaf_pkg::TGT_SHADOW;
              shadow_slots_nxt = n_slots;
              dirty_nxt        = 1'b1;
            end else begin
              res.write_target = adaf_pkg::TGT_LIVE;
            end
            acc_cnt_nxt        = acc_cnt_r + 32'd1;
            plast_nxt          = now_r;
            res.sender_swapped = other_sender;
            psender_nxt        = item.sender_ip;
            pvalid_nxt         = 1'b1;
          end
        end
      end
    endcase

    res.in_sync_mode    = sync_nxt;
    res.stale_total     = stale_cnt_nxt;
    res.locked_total    = locked_cnt_nxt;
    res.accepted_total  = acc_cnt_nxt;
    res.bad_proto_total = bad_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r          <= '0;
      pvalid_r       <= 1'b0;
      psender_r      <= '0;
      plast_r        <= '0;
      lseq_r         <= '0;
      lseq_sender_r  <= '0;
      sync_r         <= 1'b0;
      last_sync_r    <= '0;
      dirty_r        <= 1'b0;
      shadow_slots_r <= '0;
      stale_cnt_r    <= '0;
      locked_cnt_r   <= '0;
      acc_cnt_r      <= '0;
      bad_cnt_r      <= '0;
    end else if (fire) begin
      now_r          <= now_nxt;
      pvalid_r       <= pvalid_nxt;
      psender_r      <= psender_nxt;
      plast_r        <= plast_nxt;
      lseq_r         <= lseq_nxt;
      lseq_sender_r  <= lseq_sender_nxt;
      sync_r         <= sync_nxt;
      last_sync_r    <= last_sync_nxt;
      dirty_r        <= dirty_nxt;
      shadow_slots_r <= shadow_slots_nxt;
      stale_cnt_r    <= stale_cnt_nxt;
      locked_cnt_r   <= locked_cnt_nxt;
      acc_cnt_r      <= acc_cnt_nxt;
      bad_cnt_r      <= bad_cnt_nxt;
    end
  end

endmodule
